/* rtl/energy_pulse_window_counter_core_macros.svh */
// -----------------------------------------------------------------------------
// Energy pulse window counter: assertion macros
// Concurrent check macros; they compile to nothing when SYNTH is defined.
// -----------------------------------------------------------------------------
`ifndef ENERGY_PULSE_WINDOW_COUNTER_CORE_MACROS_SVH
`define ENERGY_PULSE_WINDOW_COUNTER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define EPWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define EPWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EPWC_ASSERT_NOW(lbl, ante, cons, msg)
`define EPWC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/epwc_pkg.sv */
// -----------------------------------------------------------------------------
// Energy pulse window counter: package
// Shared widths, codes, reset values and controller/datapath bundles.
// -----------------------------------------------------------------------------
package epwc_pkg;

  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int WIN_W      = 24;
  localparam int TMO_W      = 16;
  localparam int PPR_W      = 8;
  localparam int CH_IN_W    = 2;
  localparam int IDX_MAX_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int EV_W       = 2;

  // event codes, also used as the emission phase
  localparam logic [EV_W-1:0] EV_ABSENT = 2'd0;
  localparam logic [EV_W-1:0] EV_PERIOD = 2'd1;
  localparam logic [EV_W-1:0] EV_REPORT = 2'd2;

  // input kinds
  localparam logic KIND_PULSE = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ABSENCE_TIMEOUT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODS_PER_REPORT = 2'd2;

  localparam logic [TMO_W-1:0] ABSENCE_TIMEOUT_RST    = 16'd3000;
  localparam logic [TMO_W-1:0] SAMPLE_PERIOD_RST      = 16'd5000;
  localparam logic [PPR_W-1:0] PERIODS_PER_REPORT_RST = 8'd12;

  typedef struct packed {
    logic                 pulse;  // apply a pulse word
    logic                 start;  // latch time of a check word
    logic                 eval;   // absence test on channel idx
    logic                 pchk;   // period and report decision
    logic                 emit;   // load output register
    logic [EV_W-1:0]      phase;
    logic [IDX_MAX_W-1:0] idx;
  } epwc_cmd_t;

  typedef struct packed {
    logic sel;       // current slot produces a result
    logic more;      // a later slot of this pass produces a result
    logic out_free;  // output register can take a word
  } epwc_stat_t;

endpackage

/* rtl/epwc_in_if.sv */
// -----------------------------------------------------------------------------
// Energy pulse window counter: input channel
// Valid/ready channel carrying pulse and check words.
// -----------------------------------------------------------------------------
interface epwc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  channel;
  logic [31:0] now;

  modport source (output valid, output kind, output channel, output now, input ready);
  modport sink   (input valid, input kind, input channel, input now, output ready);
endinterface

/* rtl/epwc_out_if.sv */
// -----------------------------------------------------------------------------
// Energy pulse window counter: result channel
// Valid/ready channel carrying event words.
// -----------------------------------------------------------------------------
interface epwc_out_if;
  logic        valid;
  logic        ready;
  logic        channel_id;
  logic [1:0]  event_type;
  logic [23:0] window_ticks;
  logic [31:0] value;
  logic        last;

  modport source (output valid, output channel_id, output event_type,
                  output window_ticks, output value, output last, input ready);
  modport sink   (input valid, input channel_id, input event_type,
                  input window_ticks, input value, input last, output ready);
endinterface

/* rtl/epwc_cfg_if.sv */
// -----------------------------------------------------------------------------
// Energy pulse window counter: configuration write channel
// Valid/ready channel carrying a register index and write data.
// -----------------------------------------------------------------------------
interface epwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/epwc_datapath.sv */
// -----------------------------------------------------------------------------
// Energy pulse window counter: datapath
// Channel counters, timers, decision flags, config registers, output register.
// -----------------------------------------------------------------------------
`include "energy_pulse_window_counter_core_macros.svh"

module epwc_datapath #(
  parameter int CHANNELS = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  epwc_pkg::epwc_cmd_t                    cmd_i,
  output epwc_pkg::epwc_stat_t                   stat_o,
  input  logic [epwc_pkg::CH_IN_W-1:0]           in_channel_i,
  input  logic [epwc_pkg::TIME_W-1:0]            in_now_i,
  input  logic                                   cfg_we_i,
  input  logic [epwc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [epwc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   out_channel_id_o,
  output logic [epwc_pkg::EV_W-1:0]              out_event_type_o,
  output logic [epwc_pkg::WIN_W-1:0]             out_window_ticks_o,
  output logic [epwc_pkg::COUNT_W-1:0]           out_value_o,
  output logic                                   out_last_o
);
  import epwc_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [TMO_W-1:0]   abs_tmo_q;
  logic [TMO_W-1:0]   per_len_q;
  logic [PPR_W-1:0]   ppr_q;

  logic [TIME_W-1:0]  lpt_q    [CHANNELS];
  logic [COUNT_W-1:0] pulses_q [CHANNELS];
  logic [COUNT_W-1:0] sum_q    [CHANNELS];
  logic [TIME_W-1:0]  pst_q;
  logic [PPR_W-1:0]   pc_q;
  logic [TIME_W-1:0]  now_q;
  logic [CHANNELS-1:0] mask_q;
  logic               per_q;
  logic               rep_q;
  logic [WIN_W-1:0]   win_q;

  logic               out_valid_q;
  logic               out_ch_q;
  logic [EV_W-1:0]    out_ev_q;
  logic [WIN_W-1:0]   out_win_q;
  logic [COUNT_W-1:0] out_val_q;
  logic               out_last_q;

  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   pch;
  logic               pch_ok;
  logic               idx_last;
  logic [TIME_W-1:0]  idle_ticks;
  logic               absent;
  logic [TIME_W-1:0]  since_start;
  logic               per_d;
  logic [PPR_W-1:0]   pc_inc;
  logic               rep_d;
  logic               abs_above;
  logic [WIN_W-1:0]   emit_win;
  logic [COUNT_W-1:0] emit_val;

  assign idx      = cmd_i.idx[IDX_W-1:0];
  assign pch      = in_channel_i[IDX_W-1:0];
  assign pch_ok   = ({1'b0, in_channel_i} < 3'(CHANNELS));
  assign idx_last = (idx == IDX_W'(CHANNELS - 1));

  // absence test for the channel under evaluation
  assign idle_ticks = now_q - lpt_q[idx];
  assign absent     = (idle_ticks > {{(TIME_W-TMO_W){1'b0}}, abs_tmo_q});

  // period close and long-window decision
  assign since_start = now_q - pst_q;
  assign per_d       = (since_start >= {{(TIME_W-TMO_W){1'b0}}, per_len_q});
  assign pc_inc      = per_d ? pc_q + 8'd1 : pc_q;
  assign rep_d       = (pc_inc >= ppr_q);

  always_comb begin
    abs_above = 1'b0;
    for (int j = 0; j < CHANNELS; j++) begin
      if (j > int'(idx)) begin
        abs_above = abs_above | mask_q[j];
      end
    end
  end

  always_comb begin
    stat_o.out_free = !out_valid_q || out_ready_i;
    case (cmd_i.phase)
      EV_ABSENT: begin
        stat_o.sel  = mask_q[idx];
        stat_o.more = abs_above || per_q || rep_q;
        emit_win    = {{(WIN_W-TMO_W){1'b0}}, abs_tmo_q};
        emit_val    = '0;
      end
      EV_PERIOD: begin
        stat_o.sel  = per_q;
        stat_o.more = !idx_last || rep_q;
        emit_win    = {{(WIN_W-TMO_W){1'b0}}, per_len_q};
        emit_val    = pulses_q[idx];
      end
      EV_REPORT: begin
        stat_o.sel  = rep_q;
        stat_o.more = !idx_last;
        emit_win    = win_q;
        emit_val    = sum_q[idx];
      end
      default: begin
        stat_o.sel  = 1'b0;
        stat_o.more = 1'b0;
        emit_win    = '0;
        emit_val    = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_tmo_q <= ABSENCE_TIMEOUT_RST;
      per_len_q <= SAMPLE_PERIOD_RST;
      ppr_q     <= PERIODS_PER_REPORT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ABSENCE_TIMEOUT:    abs_tmo_q <= cfg_data_i;
        REG_SAMPLE_PERIOD:      per_len_q <= cfg_data_i;
        REG_PERIODS_PER_REPORT: ppr_q     <= cfg_data_i[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  // channel and period state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lpt_q[i]    <= '0;
        pulses_q[i] <= '0;
        sum_q[i]    <= '0;
      end
      pst_q  <= '0;
      pc_q   <= '0;
      mask_q <= '0;
      per_q  <= 1'b0;
      rep_q  <= 1'b0;
    end else begin
      if (cmd_i.pulse && pch_ok) begin
        pulses_q[pch] <= pulses_q[pch] + 32'd1;
        lpt_q[pch]    <= in_now_i;
      end
      if (cmd_i.eval) begin
        mask_q[idx] <= absent;
        if (absent) begin
          lpt_q[idx] <= now_q;
        end
      end
      if (cmd_i.pchk) begin
        per_q <= per_d;
        rep_q <= rep_d;
        if (per_d) begin
          pst_q <= now_q;
        end
        pc_q <= rep_d ? '0 : pc_inc;
      end
      if (cmd_i.emit) begin
        if (cmd_i.phase == EV_PERIOD) begin
          sum_q[idx]    <= sum_q[idx] + pulses_q[idx];
          pulses_q[idx] <= '0;
        end else if (cmd_i.phase == EV_REPORT) begin
          sum_q[idx] <= '0;
        end
      end
    end
  end

  // pass operands, no reset needed; the long window is a full 24-bit product
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      now_q <= in_now_i;
    end
    if (cmd_i.pchk) begin
      win_q <= WIN_W'(per_len_q) * WIN_W'(ppr_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_ch_q   <= cmd_i.idx[0];
      out_ev_q   <= cmd_i.phase;
      out_win_q  <= emit_win;
      out_val_q  <= emit_val;
      out_last_q <= !stat_o.more;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_channel_id_o   = out_ch_q;
  assign out_event_type_o   = out_ev_q;
  assign out_window_ticks_o = out_win_q;
  assign out_value_o        = out_val_q;
  assign out_last_o         = out_last_q;

  `EPWC_ASSERT_NEXT(a_rep_clears_counter, cmd_i.pchk, !rep_q || pc_q == '0,
                    "period counter not cleared on long-window report")
  `EPWC_ASSERT_NEXT(a_period_clears_count, cmd_i.emit && cmd_i.phase == EV_PERIOD,
                    pulses_q[$past(idx)] == '0, "period count not cleared after emit")

endmodule

/* rtl/epwc_ctrl.sv */
// -----------------------------------------------------------------------------
// Energy pulse window counter: controller
// Sequences the absence walk, the period decision and the result emission.
// -----------------------------------------------------------------------------
`include "energy_pulse_window_counter_core_macros.svh"

module epwc_ctrl #(
  parameter int CHANNELS = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_kind_i,
  output logic                  in_ready_o,
  input  epwc_pkg::epwc_stat_t  stat_i,
  output epwc_pkg::epwc_cmd_t   cmd_o
);
  import epwc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_PCHK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [IDX_MAX_W-1:0] LAST_IDX = IDX_MAX_W'(CHANNELS - 1);

  logic [1:0]           state_q, state_d;
  logic [EV_W-1:0]      phase_q, phase_d;
  logic [IDX_MAX_W-1:0] idx_q, idx_d;
  logic                 accept;
  logic                 stall;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign stall      = stat_i.sel && !stat_i.out_free;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    cmd_o.idx   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_kind_i == KIND_CHECK) begin
            cmd_o.start = 1'b1;
            idx_d       = '0;
            state_d     = S_EVAL;
          end else begin
            cmd_o.pulse = 1'b1;
          end
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = S_PCHK;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_PCHK: begin
        cmd_o.pchk = 1'b1;
        phase_d    = EV_ABSENT;
        idx_d      = '0;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        // hold on a result that cannot leave yet, otherwise advance
        if (!stall) begin
          cmd_o.emit = stat_i.sel;
          if (idx_q == LAST_IDX) begin
            idx_d = '0;
            case (phase_q)
              EV_ABSENT: phase_d = EV_PERIOD;
              EV_PERIOD: phase_d = EV_REPORT;
              default:   state_d = S_IDLE;
            endcase
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= EV_ABSENT;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  `EPWC_ASSERT_NOW(a_emit_needs_slot, cmd_o.emit, stat_i.out_free && stat_i.sel,
                   "emit without a free output slot")
  `EPWC_ASSERT_NEXT(a_pass_ends_idle,
                    state_q == S_EMIT && phase_q == EV_REPORT && idx_q == LAST_IDX && !stall,
                    state_q == S_IDLE, "pass did not end after the last report slot")
  `EPWC_ASSERT_NEXT(a_check_starts_walk, accept && in_kind_i == KIND_CHECK,
                    state_q == S_EVAL && idx_q == '0, "check word did not start the walk")

endmodule

/* rtl/energy_pulse_window_counter_core.sv */
// A pulse word is applied in the cycle it is accepted and gives no result.
// A check word runs one absence test per channel, one period decision, then
// 3*CHANNELS emission slots; a result the output cannot take holds the walk.
// Words are taken one at a time; the next is taken once the emission walk is done.
// Reset (rst_ni low, asynchronous): counters, timers and sums clear, config registers
// return to 3000 / 5000 / 12, the output register empties.
// -----------------------------------------------------------------------------
// Energy pulse window counter core
// Multi-channel meter pulse counter with load-absent, period and long-window
// events.
// -----------------------------------------------------------------------------
`include "energy_pulse_window_counter_core_macros.svh"

module energy_pulse_window_counter_core #(
  parameter int CHANNELS = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  epwc_in_if.sink   in_i,
  epwc_out_if.source out_o,
  epwc_cfg_if.sink  cfg_i
);
  import epwc_pkg::*;

  // command and status between controller and datapath
  epwc_cmd_t  cmd;
  epwc_stat_t stat;
  logic       cfg_we;

  // config writes are always taken; the user must issue them only while idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  // Controller: walks channels for the absence test, makes the period
  // decision, then steps through the absent / period / report slots.
  epwc_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: per-channel pulse counts, last pulse times, report sums,
  // period timer and counter, and the output register that decouples the
  // result channel from the walk.
  epwc_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .in_channel_i       (in_i.channel),
    .in_now_i           (in_i.now),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .out_channel_id_o   (out_o.channel_id),
    .out_event_type_o   (out_o.event_type),
    .out_window_ticks_o (out_o.window_ticks),
    .out_value_o        (out_o.value),
    .out_last_o         (out_o.last)
  );

  // a word is only taken while no pass is running
  `EPWC_ASSERT_NOW(a_no_pulse_in_pass, cmd.pulse, !cmd.eval && !cmd.pchk && !cmd.emit,
                   "pulse word applied during a check pass")

endmodule
